>>> rtl/ptsplit_pkg.sv
// ============================================================================
// ptsplit_pkg: shared types and constants of the page translate split block
// Widths of the access and segment fields, table geometry, status codes and
// the item types passed between the front and back parts.
// ============================================================================
package ptsplit_pkg;

    // field widths
    localparam int VA_W     = 64;
    localparam int LEN_W    = 13;
    localparam int PHYS_W   = 26;
    localparam int STATUS_W = 2;

    // page geometry
    localparam int PAGE_BITS    = 18;
    localparam int PAGE_ENTRIES = 256;
    localparam int MAX_ACCESS   = 4096;
    localparam int TAG_W        = VA_W - PAGE_BITS;

    // tag table organization: rows of LANES tags compared together
    localparam int LANE_BITS = 3;
    localparam int LANES     = 1 << LANE_BITS;
    localparam int ROWS      = (PAGE_ENTRIES + LANES - 1) / LANES;
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ROW_CNT_W = $clog2(ROWS + 1);
    localparam int CNT_W     = $clog2(PAGE_ENTRIES + 1);
    localparam int SLOT_W    = $clog2(PAGE_ENTRIES);

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_WRAP = 2'd2;

    // classified access handed from front to back
    typedef struct packed {
        logic             wrap;
        logic             split;
        logic [VA_W-1:0]  va0;
        logic [LEN_W-1:0] len0;
        logic [VA_W-1:0]  va1;
        logic [LEN_W-1:0] len1;
    } job_t;

    // one segment result
    typedef struct packed {
        logic [VA_W-1:0]     seg_virt;
        logic [PHYS_W-1:0]   seg_phys;
        logic [LEN_W-1:0]    seg_len;
        logic                seg_last;
        logic [STATUS_W-1:0] status;
    } res_t;

endpackage

>>> rtl/page_translate_split_core.sv
// ============================================================================
// page_translate_split_core: first-touch page translation with page split
// Splits each access at the page boundary into one or two segments and
// translates each segment page through a first-touch allocation table.
// ============================================================================
// each segment is translated by a row-at-a-time scan of the tag table
//   (8 tags per row read)
// wrapped accesses pass through the back part with no table access
// reset clears the page count and both queues; the tag table is not cleared
module page_translate_split_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [ptsplit_pkg::VA_W-1:0]     virt_addr,
    input  logic [ptsplit_pkg::LEN_W-1:0]    byte_len,
    output logic                             empty,
    input  logic                             pop,
    output logic [ptsplit_pkg::VA_W-1:0]     seg_virt,
    output logic [ptsplit_pkg::PHYS_W-1:0]   seg_phys,
    output logic [ptsplit_pkg::LEN_W-1:0]    seg_len,
    output logic                             seg_last,
    output logic [ptsplit_pkg::STATUS_W-1:0] status
);
    import ptsplit_pkg::*;

    logic job_valid;
    logic job_pop;
    job_t job;
    res_t res;

    // classification and job queue
    ptsplit_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .virt_addr (virt_addr),
        .byte_len  (byte_len),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop)
    );

    // translation and result queue
    ptsplit_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop),
        .empty     (empty),
        .pop       (pop),
        .res       (res)
    );

    // result fields
    assign seg_virt = res.seg_virt;
    assign seg_phys = res.seg_phys;
    assign seg_len  = res.seg_len;
    assign seg_last = res.seg_last;
    assign status   = res.status;

endmodule

>>> rtl/ptsplit_front.sv
// ============================================================================
// ptsplit_front: access classification and job queue
// Normalizes the length, detects address wrap, splits the access at the
// page boundary and holds classified jobs in a two-entry queue.
// ============================================================================
module ptsplit_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [ptsplit_pkg::VA_W-1:0]  virt_addr,
    input  logic [ptsplit_pkg::LEN_W-1:0] byte_len,
    output logic                          job_valid,
    output ptsplit_pkg::job_t             job,
    input  logic                          job_pop
);
    import ptsplit_pkg::*;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);
    localparam int ROOM_W = PAGE_BITS + 1;
    localparam int CMP_W  = (ROOM_W > LEN_W) ? ROOM_W : LEN_W;

    logic [LEN_W-1:0]     len_n;
    logic [LEN_W-1:0]     len_m1;
    logic [VA_W:0]        end_sum;
    logic [ROOM_W-1:0]    room;
    logic                 split;
    logic [LEN_W-1:0]     first_len;
    job_t                 job_in;
    logic                 q_push;
    logic                 q_pop;

    job_t                 q_mem_reg [QDEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg;
    logic [QPTR_W-1:0]    wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg;
    logic [QPTR_W-1:0]    rd_ptr_next;
    logic [QCNT_W-1:0]    cnt_reg;
    logic [QCNT_W-1:0]    cnt_next;

    // length clamp into 1..MAX_ACCESS
    always_comb
    begin
        if (byte_len == '0)
            len_n = LEN_W'(1);
        else if (byte_len > LEN_W'(MAX_ACCESS))
            len_n = LEN_W'(MAX_ACCESS);
        else
            len_n = byte_len;
    end

    // wrap check: carry out of the last byte address
    assign len_m1  = len_n - LEN_W'(1);
    assign end_sum = (VA_W + 1)'(virt_addr) + (VA_W + 1)'(len_m1);

    // bytes left in the first page and the split point
    assign room      = {1'b1, {PAGE_BITS{1'b0}}} - {1'b0, virt_addr[PAGE_BITS-1:0]};
    assign split     = CMP_W'(len_n) > CMP_W'(room);
    assign first_len = split ? LEN_W'(room) : len_n;

    always_comb
    begin
        job_in.wrap  = end_sum[VA_W];
        job_in.split = split;
        job_in.va0   = virt_addr;
        job_in.len0  = first_len;
        job_in.va1   = virt_addr + VA_W'(first_len);
        job_in.len1  = len_n - first_len;
    end

    // job queue control
    assign full      = (cnt_reg == QCNT_W'(QDEPTH));
    assign job_valid = (cnt_reg != '0);
    assign job       = q_mem_reg[rd_ptr_reg];
    assign q_push    = push && !full;
    assign q_pop     = job_pop && job_valid;

    always_comb
    begin
        wr_ptr_next = q_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(q_push) - QCNT_W'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (q_push)
            q_mem_reg[wr_ptr_reg] <= job_in;
    end

endmodule

>>> rtl/ptsplit_back.sv
// ============================================================================
// ptsplit_back: segment translation and result queue
// Scans the tag table one row of lanes per cycle for each segment page,
// allocates the next slot on a miss while the table has room and queues segment results.
// ============================================================================
module ptsplit_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  ptsplit_pkg::job_t job,
    output logic              job_pop,
    output logic              empty,
    input  logic              pop,
    output ptsplit_pkg::res_t res
);
    import ptsplit_pkg::*;

    localparam int OQDEPTH = 2;
    localparam int OQPTR_W = $clog2(OQDEPTH);
    localparam int OQCNT_W = $clog2(OQDEPTH + 1);
    localparam int WIDE_W  = ROW_CNT_W + LANE_BITS + CNT_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    job_t                            job_reg;
    job_t                            job_next;
    logic                            seg_sel_reg;
    logic                            seg_sel_next;
    logic [ROW_CNT_W-1:0]            issue_row_reg;
    logic [ROW_CNT_W-1:0]            issue_row_next;
    logic                            pend_valid_reg;
    logic                            pend_valid_next;
    logic [ROW_W-1:0]                pend_row_reg;
    logic [ROW_W-1:0]                pend_row_next;
    logic [CNT_W-1:0]                pages_used_reg;
    logic [CNT_W-1:0]                pages_used_next;
    res_t                            res_reg;
    res_t                            res_next;

    logic [LANES-1:0][TAG_W-1:0]     tag_mem [ROWS];
    logic [LANES-1:0][TAG_W-1:0]     row_data_reg;

    logic [VA_W-1:0]                 cur_va;
    logic [LEN_W-1:0]                cur_len;
    logic [TAG_W-1:0]                cur_tag;
    logic [PAGE_BITS-1:0]            cur_off;
    logic [WIDE_W-1:0]               used_wide;
    logic [WIDE_W-1:0]               issue_base;
    logic                            issue_done;
    logic                            table_full;
    logic [LANES-1:0]                lane_match;
    logic                            hit_now;
    logic [LANE_BITS-1:0]            hit_lane;
    logic [SLOT_W-1:0]               hit_slot;
    logic [SLOT_W-1:0]               sel_slot;
    logic [PHYS_W+SLOT_W+PAGE_BITS-1:0] phys_wide;
    logic [LANE_BITS-1:0]            wr_lane;
    logic [ROW_W-1:0]                wr_row;
    logic                            tbl_we;
    logic                            rd_en;
    logic                            oq_push;
    logic                            oq_pop;
    logic                            oq_full;

    res_t                            oq_mem_reg [OQDEPTH];
    logic [OQPTR_W-1:0]              oq_wr_reg;
    logic [OQPTR_W-1:0]              oq_wr_next;
    logic [OQPTR_W-1:0]              oq_rd_reg;
    logic [OQPTR_W-1:0]              oq_rd_next;
    logic [OQCNT_W-1:0]              oq_cnt_reg;
    logic [OQCNT_W-1:0]              oq_cnt_next;

    // current segment
    assign cur_va  = seg_sel_reg ? job_reg.va1 : job_reg.va0;
    assign cur_len = seg_sel_reg ? job_reg.len1 : job_reg.len0;
    assign cur_tag = cur_va[VA_W-1:PAGE_BITS];
    assign cur_off = cur_va[PAGE_BITS-1:0];

    // scan bounds and allocation position
    assign used_wide  = WIDE_W'(pages_used_reg);
    assign issue_base = WIDE_W'(issue_row_reg) << LANE_BITS;
    assign issue_done = (issue_base >= used_wide);
    assign table_full = (pages_used_reg == CNT_W'(PAGE_ENTRIES));
    assign wr_lane    = used_wide[LANE_BITS-1:0];
    assign wr_row     = used_wide[LANE_BITS +: ROW_W];

    // lane compare on the registered row, valid lanes only
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            lane_match[l] = (row_data_reg[l] == cur_tag) &&
                ((WIDE_W'(pend_row_reg) << LANE_BITS) + WIDE_W'(l) < used_wide);
        end
    end

    // lowest matching lane
    always_comb
    begin
        hit_lane = '0;
        for (int l = LANES - 1; l >= 0; l--)
        begin
            if (lane_match[l])
                hit_lane = LANE_BITS'(l);
        end
    end

    assign hit_now  = pend_valid_reg && (lane_match != '0);
    assign hit_slot = SLOT_W'({pend_row_reg, hit_lane});
    assign sel_slot = hit_now ? hit_slot : SLOT_W'(pages_used_reg);
    assign phys_wide = {{PHYS_W{1'b0}}, sel_slot, cur_off};

    // segment sequencer
    always_comb
    begin
        state_next      = state_reg;
        job_next        = job_reg;
        seg_sel_next    = seg_sel_reg;
        issue_row_next  = issue_row_reg;
        pend_valid_next = 1'b0;
        pend_row_next   = pend_row_reg;
        pages_used_next = pages_used_reg;
        res_next        = res_reg;
        tbl_we          = 1'b0;
        rd_en           = 1'b0;
        job_pop         = 1'b0;
        oq_push         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop        = 1'b1;
                    job_next       = job;
                    seg_sel_next   = 1'b0;
                    issue_row_next = '0;
                    if (job.wrap)
                    begin
                        res_next.seg_virt = job.va0;
                        res_next.seg_phys = '0;
                        res_next.seg_len  = '0;
                        res_next.seg_last = 1'b1;
                        res_next.status   = STATUS_WRAP;
                        state_next        = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit_now || (!pend_valid_reg && issue_done))
                begin
                    res_next.seg_virt = cur_va;
                    state_next        = ST_EMIT;
                    if (!hit_now && table_full)
                    begin
                        res_next.seg_phys = '0;
                        res_next.seg_len  = '0;
                        res_next.seg_last = 1'b1;
                        res_next.status   = STATUS_FULL;
                    end
                    else
                    begin
                        // miss with room left takes the next slot
                        if (!hit_now)
                        begin
                            tbl_we          = 1'b1;
                            pages_used_next = pages_used_reg + CNT_W'(1);
                        end
                        res_next.seg_phys = phys_wide[PHYS_W-1:0];
                        res_next.seg_len  = cur_len;
                        res_next.seg_last = !job_reg.split || seg_sel_reg;
                        res_next.status   = STATUS_OK;
                    end
                end
                else if (!issue_done)
                begin
                    rd_en           = 1'b1;
                    issue_row_next  = issue_row_reg + ROW_CNT_W'(1);
                    pend_valid_next = 1'b1;
                    pend_row_next   = issue_row_reg[ROW_W-1:0];
                end
            end
            ST_EMIT:
            begin
                if (!oq_full)
                begin
                    oq_push = 1'b1;
                    if (res_reg.seg_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        seg_sel_next   = 1'b1;
                        issue_row_next = '0;
                        state_next     = ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            seg_sel_reg    <= 1'b0;
            issue_row_reg  <= '0;
            pend_valid_reg <= 1'b0;
            pages_used_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            seg_sel_reg    <= seg_sel_next;
            issue_row_reg  <= issue_row_next;
            pend_valid_reg <= pend_valid_next;
            pages_used_reg <= pages_used_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        pend_row_reg <= pend_row_next;
        res_reg      <= res_next;
    end

    // tag table: lane write, registered row read
    always_ff @(posedge clk)
    begin
        if (tbl_we)
            tag_mem[wr_row][wr_lane] <= cur_tag;
        if (rd_en)
            row_data_reg <= tag_mem[issue_row_reg[ROW_W-1:0]];
    end

    // result queue
    assign oq_full = (oq_cnt_reg == OQCNT_W'(OQDEPTH));
    assign empty   = (oq_cnt_reg == '0);
    assign res     = oq_mem_reg[oq_rd_reg];
    assign oq_pop  = pop && !empty;

    always_comb
    begin
        oq_wr_next  = oq_push ? oq_wr_reg + OQPTR_W'(1) : oq_wr_reg;
        oq_rd_next  = oq_pop ? oq_rd_reg + OQPTR_W'(1) : oq_rd_reg;
        oq_cnt_next = oq_cnt_reg + OQCNT_W'(oq_push) - OQCNT_W'(oq_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            oq_wr_reg  <= oq_wr_next;
            oq_rd_reg  <= oq_rd_next;
            oq_cnt_reg <= oq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
            oq_mem_reg[oq_wr_reg] <= res_reg;
    end

    // checks
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pages_used_reg <= CNT_W'(PAGE_ENTRIES))
        else $error("pages in use exceed table size");

    a_alloc_room: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_we |-> !table_full && !hit_now)
        else $error("allocation on hit or on full table");

    a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_we |=> pages_used_reg == $past(pages_used_reg) + CNT_W'(1))
        else $error("allocation did not advance page count");

    a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        oq_cnt_reg <= OQCNT_W'(OQDEPTH))
        else $error("result queue overflow");

    a_emit_push: assert property (@(posedge clk) disable iff (!rst_n)
        oq_push |-> state_reg == ST_EMIT && !oq_full)
        else $error("result pushed outside emit");

endmodule
